### src/binary_to_decimal_ascii_assert.svh
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef SYNTHESIS

`define B2DA_ASSERT_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define B2DA_ASSERT_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

`define B2DA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define B2DA_ASSERT_HOLDS(lbl, expr)
`define B2DA_ASSERT_IMPLIES(lbl, pre, post)
`define B2DA_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

### src/b2da_pkg.sv
package b2da_pkg;

  localparam int VALUE_BITS      = 32;
  localparam int STEPS_PER_STAGE = 8;
  localparam int NUM_STAGES      = (VALUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int PAD_BITS        = NUM_STAGES * STEPS_PER_STAGE;
  localparam int MAX_DIGITS      = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BCD_W           = 4 * MAX_DIGITS;
  localparam int IDX_W           = $clog2(MAX_DIGITS);
  localparam int CHAR_W          = 6;
  localparam int IN_TDATA_W      = 32;
  localparam int OUT_TDATA_W     = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
  localparam logic [3:0]        DABBLE_MIN = 4'd5;
  localparam logic [3:0]        DABBLE_ADD = 4'd3;
  localparam logic [3:0]        DIGIT_MAX  = 4'd9;

  typedef struct packed {
    logic [BCD_W-1:0]    bcd;
    logic [PAD_BITS-1:0] bin;
  } work_t;

  function automatic work_t dabble_step(work_t w);
    work_t      r;
    logic [3:0] d;
    r = w;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      d = r.bcd[4*i +: 4];
      if (d >= DABBLE_MIN) begin
        r.bcd[4*i +: 4] = d + DABBLE_ADD;
      end
    end
    {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
    return r;
  endfunction

  function automatic logic digits_ok(logic [BCD_W-1:0] bcd);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[4*i +: 4] > DIGIT_MAX) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

### src/binary_to_decimal_ascii.sv
// Channel   Direction  tdata                                   tlast
// s_axis    in         value[31:0]                             -
// m_axis    out        digit_char[5:0], zero[7:6]              last_digit
//
// Four shift-and-adjust stages of eight steps each turn the value into BCD;
// an item can enter every cycle while the output side keeps up.
// The output serialiser sends one character per cycle while m_axis_tready is high, one to ten per item,
// and it takes the next item as the last character of the current one is accepted.
// A value passes through every stage register before the serialiser loads it.
// Reset is synchronous and clears the valid flags and the digit index; a stall on m_axis
// holds the serialiser, and each stage holds its item while the stage after it cannot take it.
module binary_to_decimal_ascii (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [b2da_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // value[31:0]
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [b2da_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // digit_char[5:0], zero[7:6]
  output logic                                 m_axis_tlast
);
  import b2da_pkg::*;

  logic  st_valid [NUM_STAGES+1];
  logic  st_ready [NUM_STAGES+1];
  work_t st_data  [NUM_STAGES+1];

  assign st_valid[0]     = s_axis_tvalid;
  assign s_axis_tready   = st_ready[0];
  assign st_data[0].bcd  = '0;
  assign st_data[0].bin  = PAD_BITS'(s_axis_tdata[VALUE_BITS-1:0]);

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    b2da_dabble_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[g]),
      .in_ready  (st_ready[g]),
      .in_data   (st_data[g]),
      .out_valid (st_valid[g+1]),
      .out_ready (st_ready[g+1]),
      .out_data  (st_data[g+1])
    );
  end

  b2da_serializer u_ser (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (st_valid[NUM_STAGES]),
    .in_ready      (st_ready[NUM_STAGES]),
    .in_data       (st_data[NUM_STAGES]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### src/b2da_dabble_stage.sv
`include "binary_to_decimal_ascii_assert.svh"

module b2da_dabble_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  b2da_pkg::work_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output b2da_pkg::work_t   out_data
);
  import b2da_pkg::*;

  logic  valid;
  work_t data;
  work_t data_next;

  always_comb begin
    data_next = in_data;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      data_next = dabble_step(data_next);
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  `B2DA_ASSERT_IMPLIES(a_stage_bcd_valid, valid, digits_ok(data.bcd))
  `B2DA_ASSERT_NEXT(a_stage_fill, in_valid && in_ready, valid)
  `B2DA_ASSERT_NEXT(a_stage_hold, valid && !out_ready, valid && $stable(data))

endmodule

### src/b2da_serializer.sv
`include "binary_to_decimal_ascii_assert.svh"

module b2da_serializer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  b2da_pkg::work_t                      in_data,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [b2da_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast
);
  import b2da_pkg::*;

  logic             busy;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] lead;
  logic [BCD_W-1:0] bcd;
  logic [3:0]       cur_digit;
  logic [CHAR_W-1:0] digit_char;
  logic             load;

  // The most significant non-zero digit opens the run; zero gives one digit.
  always_comb begin
    lead = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (in_data.bcd[4*i +: 4] != 4'd0) begin
        lead = IDX_W'(i);
      end
    end
  end

  assign cur_digit     = bcd[4*idx +: 4];
  assign digit_char    = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, cur_digit};
  assign m_axis_tvalid = busy;
  assign m_axis_tlast  = (idx == '0);
  assign m_axis_tdata  = {{(OUT_TDATA_W-CHAR_W){1'b0}}, digit_char};
  assign in_ready      = !busy || (m_axis_tready && m_axis_tlast);
  assign load          = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= lead;
    end else if (busy && m_axis_tready) begin
      if (m_axis_tlast) begin
        busy <= 1'b0;
      end else begin
        idx <= idx - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd <= in_data.bcd;
    end
  end

  `B2DA_ASSERT_IMPLIES(a_ser_digit_range, busy, cur_digit <= DIGIT_MAX)
  `B2DA_ASSERT_NEXT(a_ser_leading_digit, load, idx == '0 || cur_digit != 4'd0)
  `B2DA_ASSERT_NEXT(a_ser_count_down, busy && m_axis_tready && !m_axis_tlast, busy && idx == $past(idx) - 1'b1)

endmodule

### test/binary_to_decimal_ascii_checker.sv
`timescale 1ns / 100ps

module binary_to_decimal_ascii_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [b2da_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // value[31:0]
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [b2da_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // digit_char[5:0], zero[7:6]
  input  logic                              m_axis_tlast,
  output int                                mismatches,
  output int                                chars_pending,
  output int                                chars_checked
);
  import b2da_pkg::*;

  localparam int DECIMAL_BASE = 10;

  typedef struct packed {
    logic [OUT_TDATA_W-1:0] char_word;
    logic                   last_digit;
  } digit_t;

  digit_t expected_digits[$];
  int     error_count   = 0;
  int     pending_count = 0;
  int     checked_count = 0;

  assign mismatches    = error_count;
  assign chars_pending = pending_count;
  assign chars_checked = checked_count;

  function automatic void predict_digits(input logic [IN_TDATA_W-1:0] raw);
    logic [VALUE_BITS-1:0] rest;
    logic [3:0]            digit_rev [MAX_DIGITS];
    int                    count;
    digit_t                d;
    rest  = raw[VALUE_BITS-1:0];
    count = 0;
    if (rest == '0) begin
      digit_rev[0] = 4'd0;
      count        = 1;
    end else begin
      while (rest != '0 && count < MAX_DIGITS) begin
        digit_rev[count] = 4'(rest % DECIMAL_BASE);
        rest             = rest / DECIMAL_BASE;
        count++;
      end
    end
    for (int k = 0; k < count; k++) begin
      d.char_word  = OUT_TDATA_W'(ASCII_ZERO + CHAR_W'(digit_rev[count-1-k]));
      d.last_digit = (k == count - 1);
      expected_digits.push_back(d);
    end
  endfunction

  always @(posedge clk) begin : watch
    digit_t want;
    int     bad;
    bad = 0;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_digits(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_digits.size() == 0) begin
          bad = 1;
          $display("%0t: unexpected character word: expected none, actual tdata=%h tlast=%b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = expected_digits.pop_front();
          checked_count <= checked_count + 1;
          if (m_axis_tdata !== want.char_word) begin
            bad = 1;
            $display("%0t: character mismatch: expected %h, actual %h",
                     $time, want.char_word, m_axis_tdata);
          end
          if (m_axis_tlast !== want.last_digit) begin
            bad = 1;
            $display("%0t: last digit flag mismatch: expected %b, actual %b",
                     $time, want.last_digit, m_axis_tlast);
          end
        end
      end
      error_count   <= error_count + bad;
      pending_count <= expected_digits.size();
    end
  end

endmodule

### test/binary_to_decimal_ascii_test.sv
`timescale 1ns / 100ps

module binary_to_decimal_ascii_test;
  import b2da_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_STALL    = 300;
  localparam int ITEMS_PER_RUN = 145;
  localparam int SETTLE_CYCLES = 40;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int mismatches;
  int chars_pending;
  int chars_checked;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int stall_requests = 0;
  int stalls_done    = 0;
  int words_sent     = 0;
  int cycle_count    = 0;

  logic [31:0] directed_values [$] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd19, 32'd90, 32'd99, 32'd100, 32'd255, 32'd256,
    32'd65535, 32'd65536, 32'd1000000, 32'd123456789, 32'd999999999, 32'd1000000000,
    32'd1234567890, 32'd2147483647, 32'd2147483648, 32'd4000000000, 32'hAAAAAAAA,
    32'h55555555, 32'd4294967294, 32'd4294967295, 32'd8
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  binary_to_decimal_ascii uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  binary_to_decimal_ascii_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .chars_pending (chars_pending),
    .chars_checked (chars_checked)
  );

  function automatic logic [31:0] random_value();
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      8: begin
        repeat ($urandom_range(0, 9)) p = p * 32'd10;
        return p + $urandom_range(0, 2) - 32'd1;
      end
      9:       return $urandom_range(0, 20);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic send_value(input logic [31:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (stalls_done != stall_requests) begin
        stalls_done++;
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL - 1) @(posedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst           <= 1'b0;
    send_idle_pct <= 32;
    recv_idle_pct <= 60;
    foreach (directed_values[i]) send_value(directed_values[i]);
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct <= 60;
        recv_idle_pct <= 32;
      end else if (phase == 2) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      for (int i = 0; i < ITEMS_PER_RUN; i++) begin
        if (phase == 2 && i == 40) stall_requests <= stall_requests + 1;
        send_value(random_value());
      end
      drain_results();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Converted %0d values into %0d checked characters across three idling phases,",
             words_sent, chars_checked);
    $display("with a long output hold-off and a full drain of results after each phase.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/b2da_pkg.sv
src/b2da_dabble_stage.sv
src/b2da_serializer.sv
src/binary_to_decimal_ascii.sv
test/binary_to_decimal_ascii_checker.sv
test/binary_to_decimal_ascii_test.sv
